>>> rtl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// Types and constants shared by the matrix text parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned VALUE_W   = 12;
  localparam int unsigned ACCUM_W   = 13;
  localparam int unsigned INDEX_W   = 6;
  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 12'd4095;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_COMMA,
    CLS_SEMI,
    CLS_BAD
  } char_class_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } out_kind_t;

  typedef enum logic [2:0] {
    ERR_VALUE    = 3'd0,
    ERR_ROWS     = 3'd1,
    ERR_ROW_LONG = 3'd2,
    ERR_MISMATCH = 3'd3,
    ERR_BAD_CHAR = 3'd4
  } error_code_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        is_first;
    logic        is_final;
    logic        sel;
  } mtp_item_t;

  typedef struct packed {
    out_kind_t           kind;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
    error_code_t         code;
    logic                dest;
  } mtp_result_t;

endpackage

`default_nettype wire

>>> rtl/mtp_front.sv
// ----------------------------------------------------------------------------
// mtp_front
// Input side: takes character transactions and classifies each character.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_front import mtp_pkg::*; (
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // char_byte
  input  wire logic [1:0] in_tuser,   // first_char, matrix_select
  input  wire logic       in_tlast,   // final_char
  output logic            push,
  output mtp_item_t       push_item,
  input  wire logic       queue_ready
);

  logic [7:0] digit_full;

  assign in_tready  = queue_ready;
  assign push       = in_tvalid & queue_ready;
  assign digit_full = in_tdata - CHAR_ZERO;

  always_comb begin
    push_item          = '0;
    push_item.digit    = digit_full[3:0];
    push_item.is_first = in_tuser[0];
    push_item.sel      = in_tuser[1];
    push_item.is_final = in_tlast;
    priority if (in_tdata >= CHAR_ZERO && in_tdata <= CHAR_NINE) begin
      push_item.cls = CLS_DIGIT;
    end else if (in_tdata == CHAR_COMMA) begin
      push_item.cls = CLS_COMMA;
    end else if (in_tdata == CHAR_SEMI) begin
      push_item.cls = CLS_SEMI;
    end else begin
      push_item.cls = CLS_BAD;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mtp_queue.sv
// ----------------------------------------------------------------------------
// mtp_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_queue import mtp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire mtp_item_t push_item,
  output logic           ready,
  output logic           valid,
  output mtp_item_t      head,
  input  wire logic      pop
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  mtp_item_t       entry_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;

  assign ready = (count_r != NW'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mtp_back.sv
// ----------------------------------------------------------------------------
// mtp_back
// Parse engine: value accumulation, row bookkeeping, error checks and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_back import mtp_pkg::*; #(
  parameter int unsigned MAX_SIDE = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  input  wire logic [11:0]   cfg_data,
  input  wire logic          q_valid,
  input  wire mtp_item_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mtp_result_t        out_res
);

  localparam int unsigned QW = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam logic [QW-1:0] SIDE = QW'(MAX_SIDE);

  logic [VALUE_W-1:0] max_r;
  logic [ACCUM_W-1:0] accum_r, accum_nxt;
  logic [QW-1:0]      row_r, row_nxt;
  logic [QW-1:0]      frl_r, frl_nxt;
  logic [QW-1:0]      quot_r, quot_nxt;
  logic [QW-1:0]      rem_r, rem_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               err_r, err_nxt;
  logic               dest_r, dest_nxt;
  logic               out_valid_r, out_valid_nxt;
  mtp_result_t        res_r, res_nxt;

  logic [ACCUM_W-1:0] b_accum;
  logic [QW-1:0]      b_row, b_frl, b_quot, b_rem, row_inc, rem_inc;
  logic [CW-1:0]      b_cnt;
  logic               b_err;
  logic [16:0]        new_val;
  logic               produce;

  assign q_pop     = q_valid & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    b_accum = q_head.is_first ? '0 : accum_r;
    b_row   = q_head.is_first ? '0 : row_r;
    b_frl   = q_head.is_first ? '0 : frl_r;
    b_quot  = q_head.is_first ? '0 : quot_r;
    b_rem   = q_head.is_first ? '0 : rem_r;
    b_cnt   = q_head.is_first ? '0 : cnt_r;
    b_err   = q_head.is_first ? 1'b0 : err_r;
    row_inc = b_row + 1'b1;
    rem_inc = b_rem + 1'b1;
    new_val = ({4'b0, b_accum} << 3) + ({4'b0, b_accum} << 1) + 17'(q_head.digit);

    accum_nxt = accum_r;
    row_nxt   = row_r;
    frl_nxt   = frl_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    dest_nxt  = dest_r;
    produce   = 1'b0;
    res_nxt   = res_r;

    if (q_pop) begin
      accum_nxt = b_accum;
      row_nxt   = b_row;
      frl_nxt   = b_frl;
      quot_nxt  = b_quot;
      rem_nxt   = b_rem;
      cnt_nxt   = b_cnt;
      err_nxt   = b_err;
      if (q_head.is_first) begin
        dest_nxt = q_head.sel;
      end
      res_nxt      = '0;
      res_nxt.kind = KIND_ERROR;
      res_nxt.dest = q_head.is_first ? q_head.sel : dest_r;

      if (!b_err) begin
        if (q_head.is_final) begin
          err_nxt      = 1'b1;
          produce      = 1'b1;
          res_nxt.kind = KIND_DONE;
        end else begin
          unique case (q_head.cls)
            CLS_DIGIT: begin
              accum_nxt = (new_val > 17'(max_r)) ? ACCUM_W'(max_r) + 1'b1
                                                 : ACCUM_W'(new_val);
            end
            CLS_BAD: begin
              err_nxt      = 1'b1;
              produce      = 1'b1;
              res_nxt.code = ERR_BAD_CHAR;
            end
            default: begin
              produce = 1'b1;
              priority if (b_accum > ACCUM_W'(max_r)) begin
                err_nxt      = 1'b1;
                res_nxt.code = ERR_VALUE;
              end else if (b_frl != '0 && b_quot >= SIDE) begin
                err_nxt      = 1'b1;
                res_nxt.code = ERR_ROWS;
              end else if (b_row >= SIDE) begin
                err_nxt      = 1'b1;
                res_nxt.code = ERR_ROW_LONG;
              end else begin
                res_nxt.kind  = KIND_WRITE;
                res_nxt.index = INDEX_W'(b_cnt);
                res_nxt.value = b_accum[VALUE_W-1:0];
                accum_nxt     = '0;
                cnt_nxt       = b_cnt + 1'b1;
                row_nxt       = row_inc;
                if (b_frl != '0) begin
                  if (rem_inc >= b_frl) begin
                    rem_nxt  = '0;
                    quot_nxt = b_quot + 1'b1;
                  end else begin
                    rem_nxt = rem_inc;
                  end
                end
                if (q_head.cls == CLS_SEMI) begin
                  row_nxt = '0;
                  if (b_frl == '0) begin
                    frl_nxt  = row_inc;
                    quot_nxt = QW'(1);
                    rem_nxt  = '0;
                  end else if (row_inc != b_frl) begin
                    err_nxt       = 1'b1;
                    res_nxt.kind  = KIND_ERROR;
                    res_nxt.index = '0;
                    res_nxt.value = '0;
                    res_nxt.code  = ERR_MISMATCH;
                  end
                end
              end
            end
          endcase
        end
      end
    end

    out_valid_nxt = out_valid_r & ~out_ready;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_VALUE_RESET;
      accum_r     <= '0;
      row_r       <= '0;
      frl_r       <= '0;
      quot_r      <= '0;
      rem_r       <= '0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      dest_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_r <= cfg_data;
      end
      accum_r     <= accum_nxt;
      row_r       <= row_nxt;
      frl_r       <= frl_nxt;
      quot_r      <= quot_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      dest_r      <= dest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/matrix_text_parser.sv
// ----------------------------------------------------------------------------
// matrix_text_parser
// Parses matrix text one character per transaction into element writes,
// done and error results.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tdata char, tuser flags, tlast final
//   out_     out  out_tvalid/out_tready  tdata index/value/code, tuser kind
//   cfg_     in   cfg_valid/cfg_ready    max_value
//
// One character per cycle sustained while out_tready stays high; a character is
// registered in a queue entry, then in the parse register set.
// While a result waits for out_tready the back holds; the two-entry queue
// takes characters until it is full, then in_tready drops.
// Reset is synchronous; max_value returns to 4095, no clearing pass.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_text_parser import mtp_pkg::*; #(
  parameter int unsigned MAX_SIDE = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic [1:0]  in_tuser,   // [0] first_char, [1] matrix_select
  input  wire logic        in_tlast,   // final_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [5:0] element_index, [17:6] element_value,
                                       // [20:18] error_code, [23:21] zero
  output logic [2:0]       out_tuser,  // [1:0] out_kind, [2] matrix_dest
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data    // max_value
);

  logic        push, q_ready, q_valid, q_pop;
  mtp_item_t   push_item, q_head;
  mtp_result_t res;

  assign cfg_ready = 1'b1;

  mtp_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .push        (push),
    .push_item   (push_item),
    .queue_ready (q_ready)
  );

  mtp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  mtp_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {3'b000, res.code, res.value, res.index};
  assign out_tuser = {res.dest, res.kind};

endmodule

`default_nettype wire

>>> rtl/mtp_checker.sv
// ----------------------------------------------------------------------------
// mtp_checker
// Port-level checks on the result channel of the matrix text parser.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_checker import mtp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_nonwrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_WRITE |-> out_tdata[17:0] == 18'd0)
    else $error("index or value set on a non-write result");

  a_code_only_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_ERROR |-> out_tdata[20:18] == 3'd0)
    else $error("error code set on a non-error result");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_ERROR |-> out_tdata[20:18] <= ERR_BAD_CHAR)
    else $error("error code out of range");

endmodule

bind matrix_text_parser mtp_checker u_mtp_checker (.*);

`default_nettype wire
